// ----- rtl/pwbr_pkg.sv -----
`timescale 1ns / 1ps

package pwbr_pkg;

   localparam int TICK_WIDTH  = 20;
   localparam int LIMIT_WIDTH = 16;
   localparam int BYTE_WIDTH  = 8;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [TICK_WIDTH-1:0] TICK_MAX = '1;
   localparam logic [TICK_WIDTH-1:0] TICK_ONE = TICK_WIDTH'(1);

   // Reset values of the configuration registers
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_SHORT_RESET     = LIMIT_WIDTH'(40);
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_LONG_RESET      = LIMIT_WIDTH'(60);
   localparam logic [BYTE_WIDTH-1:0]  FIXED_FRAME_LEN_RESET = BYTE_WIDTH'(16);

   // Sync high window scale factors
   localparam int SYNC_MAX_SCALE = 10;
   localparam int SYNC_MIN_SCALE = 6;
   localparam int SYNC_MIN_WIDTH = LIMIT_WIDTH + 3;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_LIMIT_SHORT     = 2'd0,
      CSR_LIMIT_LONG      = 2'd1,
      CSR_FIXED_FRAME_LEN = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_SYNC_LOW  = 3'd1,
      PH_SYNC_HIGH = 3'd2,
      PH_BIT_LOW   = 3'd3,
      PH_BIT_HIGH  = 3'd4
   } phase_type;

   // Configuration as seen by the decoder, with the scaled limits precomputed
   typedef struct packed {
      logic [LIMIT_WIDTH-1:0]    limit_long;
      logic [TICK_WIDTH-1:0]     sync_max;
      logic [SYNC_MIN_WIDTH-1:0] sync_min;
      logic [BYTE_WIDTH-1:0]     fixed_frame_len;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] data_byte;
      logic [BYTE_WIDTH-1:0] byte_index;
      logic                  last_of_frame;
   } result_type;

endpackage

// ----- rtl/pwbr_if.sv -----
`timescale 1ns / 1ps

interface pwbr_req_if;
   logic valid;
   logic ready;
   logic pin_level;

   modport source (output valid, output pin_level, input ready);
   modport sink   (input valid, input pin_level, output ready);
endinterface

interface pwbr_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [pwbr_pkg::BYTE_WIDTH-1:0] data_byte;
   logic [pwbr_pkg::BYTE_WIDTH-1:0] byte_index;
   logic                            last_of_frame;

   modport source (output valid, output data_byte, output byte_index,
                   output last_of_frame, input ready);
   modport sink   (input valid, input data_byte, input byte_index,
                   input last_of_frame, output ready);
endinterface

// ----- rtl/pwbr_csr.sv -----
`timescale 1ns / 1ps

module pwbr_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [pwbr_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [pwbr_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data,
   output pwbr_pkg::cfg_type                    cfg
);
   import pwbr_pkg::*;

   logic [LIMIT_WIDTH-1:0]    limit_long_ff, limit_long_in;
   logic [TICK_WIDTH-1:0]     sync_max_ff, sync_max_in;
   logic [SYNC_MIN_WIDTH-1:0] sync_min_ff, sync_min_in;
   logic [BYTE_WIDTH-1:0]     fixed_len_ff, fixed_len_in;
   logic [TICK_WIDTH-1:0]     data_x10;
   logic [SYNC_MIN_WIDTH-1:0] data_x6;

   // Scale by shift and add so the decoder sees ready-made limits
   assign data_x10 = {1'b0, csr_write_data, 3'b000} + {3'b000, csr_write_data, 1'b0};
   assign data_x6  = {1'b0, csr_write_data, 2'b00} + {2'b00, csr_write_data, 1'b0};

   always_comb begin
      limit_long_in = limit_long_ff;
      sync_max_in   = sync_max_ff;
      sync_min_in   = sync_min_ff;
      fixed_len_in  = fixed_len_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_LIMIT_SHORT: begin
               sync_min_in = data_x6;
            end
            CSR_LIMIT_LONG: begin
               limit_long_in = csr_write_data;
               sync_max_in   = data_x10;
            end
            CSR_FIXED_FRAME_LEN: begin
               fixed_len_in = csr_write_data[BYTE_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_long_ff <= LIMIT_LONG_RESET;
         sync_max_ff   <= TICK_WIDTH'(SYNC_MAX_SCALE * LIMIT_LONG_RESET);
         sync_min_ff   <= SYNC_MIN_WIDTH'(SYNC_MIN_SCALE * LIMIT_SHORT_RESET);
         fixed_len_ff  <= FIXED_FRAME_LEN_RESET;
      end else begin
         limit_long_ff <= limit_long_in;
         sync_max_ff   <= sync_max_in;
         sync_min_ff   <= sync_min_in;
         fixed_len_ff  <= fixed_len_in;
      end
   end

   assign cfg.limit_long      = limit_long_ff;
   assign cfg.sync_max        = sync_max_ff;
   assign cfg.sync_min        = sync_min_ff;
   assign cfg.fixed_frame_len = fixed_len_ff;

endmodule

// ----- rtl/pwbr_decode.sv -----
`timescale 1ns / 1ps

module pwbr_decode (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic                 pin_level,
   input  pwbr_pkg::cfg_type    cfg,
   output logic                 emit,
   output pwbr_pkg::result_type result
);
   import pwbr_pkg::*;

   phase_type              phase_ff, phase_in;
   logic                   prev_ff, prev_in;
   logic [TICK_WIDTH-1:0]  tick_ff, tick_in;
   logic [BYTE_WIDTH-1:0]  shift_ff, shift_in;
   logic [2:0]             bit_pos_ff, bit_pos_in;
   logic [BYTE_WIDTH-1:0]  byte_count_ff, byte_count_in;
   logic [BYTE_WIDTH-1:0]  frame_len_ff, frame_len_in;

   logic [TICK_WIDTH-1:0]  tick_inc;
   logic [TICK_WIDTH-1:0]  tick_hi;
   logic [TICK_WIDTH-1:0]  long_ticks;
   logic [TICK_WIDTH-1:0]  cap_ticks;
   logic                   cap_hit;
   logic                   take;
   logic                   bit_val;
   logic [BYTE_WIDTH-1:0]  shift_or;
   logic [BYTE_WIDTH-1:0]  frame_len_sel;
   logic                   last;

   assign tick_inc   = (tick_ff == TICK_MAX) ? tick_ff : tick_ff + TICK_ONE;
   assign tick_hi    = (phase_ff == PH_BIT_LOW) ? TICK_ONE : tick_inc;
   assign long_ticks = {{(TICK_WIDTH-LIMIT_WIDTH){1'b0}}, cfg.limit_long};
   assign cap_ticks  = {{(TICK_WIDTH-LIMIT_WIDTH-1){1'b0}}, cfg.limit_long, 1'b0};
   assign cap_hit    = tick_hi >= cap_ticks;

   assign shift_or      = shift_ff | (BYTE_WIDTH'(bit_val) << bit_pos_ff);
   assign frame_len_sel = (byte_count_ff != '0) ? frame_len_ff :
                          (shift_or != '0) ? shift_or : cfg.fixed_frame_len;
   assign last = ({1'b0, byte_count_ff} + 9'd1) >= {1'b0, frame_len_sel};

   always_comb begin
      phase_in      = phase_ff;
      prev_in       = prev_ff;
      tick_in       = tick_ff;
      shift_in      = shift_ff;
      bit_pos_in    = bit_pos_ff;
      byte_count_in = byte_count_ff;
      frame_len_in  = frame_len_ff;
      take          = 1'b0;
      bit_val       = 1'b0;
      emit          = 1'b0;
      if (accept) begin
         prev_in = pin_level;
         case (phase_ff)
            PH_SYNC_LOW: begin
               if (pin_level) begin
                  tick_in  = TICK_ONE;
                  phase_in = (cfg.sync_max == '0) ? PH_IDLE : PH_SYNC_HIGH;
               end
            end
            PH_SYNC_HIGH: begin
               if (pin_level) begin
                  tick_in = tick_inc;
                  if (tick_inc > cfg.sync_max)
                     phase_in = PH_IDLE;
               end else if (tick_ff <= {1'b0, cfg.sync_min}) begin
                  phase_in = PH_IDLE;
               end else begin
                  phase_in      = PH_BIT_LOW;
                  shift_in      = '0;
                  bit_pos_in    = 3'd7;
                  byte_count_in = '0;
                  frame_len_in  = '0;
                  tick_in       = '0;
               end
            end
            PH_BIT_LOW, PH_BIT_HIGH: begin
               if (pin_level) begin
                  tick_in = tick_hi;
                  if (cap_hit) begin
                     // capped bit: decode now, next high sample starts a new bit
                     phase_in = PH_BIT_LOW;
                     take     = 1'b1;
                     bit_val  = tick_hi > long_ticks;
                  end else begin
                     phase_in = PH_BIT_HIGH;
                  end
               end else if (phase_ff == PH_BIT_HIGH) begin
                  phase_in = PH_BIT_LOW;
                  take     = 1'b1;
                  bit_val  = tick_ff > long_ticks;
               end
            end
            default: begin
               // idle, and any code outside the list
               phase_in = (prev_ff && !pin_level) ? PH_SYNC_LOW : PH_IDLE;
            end
         endcase

         if (take) begin
            shift_in = shift_or;
            if (bit_pos_ff != 3'd0) begin
               bit_pos_in = bit_pos_ff - 3'd1;
            end else begin
               emit          = 1'b1;
               frame_len_in  = frame_len_sel;
               byte_count_in = (byte_count_ff == '1) ? byte_count_ff
                                                     : byte_count_ff + 8'd1;
               shift_in      = '0;
               bit_pos_in    = 3'd7;
               if (last)
                  phase_in = PH_IDLE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         prev_ff       <= 1'b1;
         tick_ff       <= '0;
         shift_ff      <= '0;
         bit_pos_ff    <= 3'd7;
         byte_count_ff <= '0;
         frame_len_ff  <= '0;
      end else begin
         phase_ff      <= phase_in;
         prev_ff       <= prev_in;
         tick_ff       <= tick_in;
         shift_ff      <= shift_in;
         bit_pos_ff    <= bit_pos_in;
         byte_count_ff <= byte_count_in;
         frame_len_ff  <= frame_len_in;
      end
   end

   assign result.data_byte     = shift_or;
   assign result.byte_index    = byte_count_ff;
   assign result.last_of_frame = last;

   // a byte only completes while bits are being timed
   assert property (@(posedge clock) disable iff (reset)
      emit |-> (phase_ff == PH_BIT_LOW || phase_ff == PH_BIT_HIGH))
      else $error("byte emitted outside bit phases");

   // outside a frame the assembler is empty and aligned to the top bit
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE || phase_ff == PH_SYNC_LOW || phase_ff == PH_SYNC_HIGH)
      |-> (bit_pos_ff == 3'd7 && shift_ff == '0))
      else $error("byte assembler not clear outside a frame");

   // a frame ending byte always drops back to idle
   assert property (@(posedge clock) disable iff (reset)
      (emit && last) |=> (phase_ff == PH_IDLE))
      else $error("frame end did not return to idle");

endmodule

// ----- rtl/pulse_width_bus_receiver.sv -----
`timescale 1ns / 1ps

// Pulse-width single-wire bus receiver. Each req transaction carries one
// sample of the bus line, and one sample is taken per cycle: a new req
// transaction is accepted every cycle unless a waiting byte is held off on
// rsp. A byte shows on rsp in the cycle after the sample that completes it.
// The rate is set by the single pass through the decoder between its state
// registers and the result register. A falling edge arms the receiver; the
// sync low is waited out, and the sync high must last more than
// 6*limit_short samples and no more than 10*limit_long. Each data bit is
// timed by its high samples (capped at 2*limit_long) and reads as 1 above
// limit_long. Bytes leave MSB first, one rsp transaction each; byte 0 is the
// length (zero selects fixed_frame_len) and last_of_frame marks the closing
// byte. The user writes registers through the csr port only while the bus
// is quiet (unchecked): 0 limit_short, 1 limit_long, 2 fixed_frame_len.
module pulse_width_bus_receiver (
   input  logic                                 clock,
   input  logic                                 reset,
   pwbr_req_if.sink                             req_chan,
   pwbr_rsp_if.source                           rsp_chan,
   input  logic                                 csr_write_enable,
   input  logic [pwbr_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [pwbr_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);
   import pwbr_pkg::*;

   cfg_type    cfg;
   result_type result;
   logic       emit;
   logic       req_accept;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, rsp_data_in;

   // Hold the configuration and its scaled limits
   pwbr_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // Advance the frame decoder by one sample per accepted transaction
   pwbr_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .pin_level (req_chan.pin_level),
      .cfg       (cfg),
      .emit      (emit),
      .result    (result)
   );

   // Accept a sample whenever the result register is free or being drained,
   // so a waiting byte never stalls the line sampling unless rsp is held off.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept     = req_chan.valid && req_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_accept && emit) begin
         // load the new byte; the old one, if any, leaves this same edge
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.data_byte     = rsp_data_ff.data_byte;
   assign rsp_chan.byte_index    = rsp_data_ff.byte_index;
   assign rsp_chan.last_of_frame = rsp_data_ff.last_of_frame;

   // a blocked result must stop sampling, or a byte could be overwritten
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("sample accepted while result register is blocked");

   // a result appears only after a sample that completed a byte
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_accept && emit))
      else $error("result raised without a completed byte");

   // a completed byte is always taken into the result register
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && emit) |=> rsp_valid_ff)
      else $error("completed byte lost");

endmodule

// ----- tb/tb_pulse_width_bus_receiver.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the pulse-width bus receiver. Each req transaction
// is one sample of the bus line. The bench keeps its own decoder of the line
// (phases, tick counting, byte assembly, frame length) and predicts every
// decoded byte. Each rsp transaction is then checked field by field against
// the oldest predicted byte. Frames are built from bit timings derived from
// the current limits: first directed cases, then randomised frames with
// occasional broken ones. Both handshakes idle at random.
module tb_pulse_width_bus_receiver;

   import pwbr_pkg::*;

   localparam int CLOCK_PERIOD = 10;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_SLACK  = 3;   // cycles waited after the last byte
   localparam int RANDOM_SAMPLES = 1350;
   localparam int RANDOM_BYTES   = 48;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data;

   pwbr_req_if req_bus ();
   pwbr_rsp_if rsp_bus ();

   pulse_width_bus_receiver uut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Register copies held by the line decoder below
   logic [LIMIT_WIDTH-1:0] cfg_short;
   logic [LIMIT_WIDTH-1:0] cfg_long;
   logic [BYTE_WIDTH-1:0]  cfg_fixed_len;

   // Line decoder state
   phase_type             line_phase;
   logic                  last_level;
   logic [TICK_WIDTH-1:0] high_ticks;
   logic [BYTE_WIDTH-1:0] byte_shift;
   logic [2:0]            next_bit_pos;
   logic [BYTE_WIDTH-1:0] bytes_done;
   logic [BYTE_WIDTH-1:0] frame_total;

   // Bytes predicted but not yet seen on rsp, oldest first
   result_type pending_bytes[$];
   result_type oldest_byte;

   // Bytes of the frame being put on the line
   logic [7:0] tx_bytes[$];

   int  failures;
   int  cycle_count;
   int  sample_count;
   int  byte_total;
   int  frames_seen;
   int  writes_done;
   int  hold_request;
   int  longest_hold;
   bit  send_idle_on;
   bit  recv_stall_on;
   bit  prev_capped;   // the last bit on the line ended at the cap, not on a low

   initial clock = 1'b0;
   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // ------------------------------------------------------------------
   // Line decoder: one call per accepted sample
   // ------------------------------------------------------------------

   // Shift in one decoded bit, MSB first; predict the byte once it is complete.
   function automatic void append_bit(input logic bit_val);
      result_type item;
      byte_shift[next_bit_pos] = byte_shift[next_bit_pos] | bit_val;
      if (next_bit_pos != 3'd0) begin
         next_bit_pos = next_bit_pos - 3'd1;
         return;
      end
      // The length byte sets the frame size; zero falls back to the register
      if (bytes_done == 8'd0)
         frame_total = (byte_shift != 8'd0) ? byte_shift : cfg_fixed_len;
      item.data_byte     = byte_shift;
      item.byte_index    = bytes_done;
      item.last_of_frame = (int'(bytes_done) + 1 >= int'(frame_total));
      pending_bytes.push_back(item);
      byte_total++;
      if (bytes_done != 8'hFF)
         bytes_done = bytes_done + 8'd1;
      byte_shift   = '0;
      next_bit_pos = 3'd7;
      if (item.last_of_frame)
         line_phase = PH_IDLE;
   endfunction

   // A high sample inside a bit: close the bit once the count hits the cap
   function automatic void check_bit_cap();
      if (32'(high_ticks) >= 2 * 32'(cfg_long)) begin
         line_phase = PH_BIT_LOW;
         append_bit(32'(high_ticks) > 32'(cfg_long));
      end else begin
         line_phase = PH_BIT_HIGH;
      end
   endfunction

   function automatic void decode_sample(input logic level);
      case (line_phase)
         PH_SYNC_LOW: begin
            if (level) begin
               high_ticks = TICK_ONE;
               line_phase = PH_SYNC_HIGH;
               if (32'(high_ticks) > SYNC_MAX_SCALE * 32'(cfg_long))
                  line_phase = PH_IDLE;
            end
         end
         PH_SYNC_HIGH: begin
            if (level) begin
               if (high_ticks != TICK_MAX)
                  high_ticks = high_ticks + TICK_ONE;
               if (32'(high_ticks) > SYNC_MAX_SCALE * 32'(cfg_long))
                  line_phase = PH_IDLE;
            end else if (32'(high_ticks) <= SYNC_MIN_SCALE * 32'(cfg_short)) begin
               // Sync high too short: drop the frame, this low does not re-arm
               line_phase = PH_IDLE;
            end else begin
               line_phase   = PH_BIT_LOW;
               byte_shift   = '0;
               next_bit_pos = 3'd7;
               bytes_done   = '0;
               frame_total  = '0;
               high_ticks   = '0;
            end
         end
         PH_BIT_LOW: begin
            if (level) begin
               high_ticks = TICK_ONE;
               check_bit_cap();
            end
         end
         PH_BIT_HIGH: begin
            if (level) begin
               if (high_ticks != TICK_MAX)
                  high_ticks = high_ticks + TICK_ONE;
               check_bit_cap();
            end else begin
               line_phase = PH_BIT_LOW;
               append_bit(32'(high_ticks) > 32'(cfg_long));
            end
         end
         default: begin
            line_phase = PH_IDLE;
            if (last_level && !level)
               line_phase = PH_SYNC_LOW;
         end
      endcase
      last_level = level;
   endfunction

   // ------------------------------------------------------------------
   // Monitor: predict on every accepted sample, check every accepted byte.
   // Predict first so that a byte can never be checked ahead of its cause.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            decode_sample(req_bus.pin_level);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_bytes.size() == 0) begin
               $error("unexpected byte: data_byte %0h byte_index %0d last_of_frame %0b",
                      rsp_bus.data_byte, rsp_bus.byte_index, rsp_bus.last_of_frame);
               failures++;
            end else begin
               oldest_byte = pending_bytes.pop_front();
               if (rsp_bus.data_byte !== oldest_byte.data_byte) begin
                  $error("data_byte: expected %0h, got %0h",
                         oldest_byte.data_byte, rsp_bus.data_byte);
                  failures++;
               end
               if (rsp_bus.byte_index !== oldest_byte.byte_index) begin
                  $error("byte_index: expected %0d, got %0d",
                         oldest_byte.byte_index, rsp_bus.byte_index);
                  failures++;
               end
               if (rsp_bus.last_of_frame !== oldest_byte.last_of_frame) begin
                  $error("last_of_frame: expected %0b, got %0b",
                         oldest_byte.last_of_frame, rsp_bus.last_of_frame);
                  failures++;
               end
               if (oldest_byte.last_of_frame)
                  frames_seen++;
            end
         end
      end
   end

   // Hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Result sink: draw a stall after each accepted byte; a hold-off request
   // from the test sequence overrides it and keeps ready low until the
   // requested count, taken over here, has run down.
   // ------------------------------------------------------------------
   initial begin : result_sink
      int   gap_left;
      logic took;
      rsp_bus.ready = 1'b0;
      gap_left      = 0;
      forever begin
         @(posedge clock);
         took = rsp_bus.valid && rsp_bus.ready;
         @(negedge clock);
         if (hold_request > 0) begin
            gap_left = hold_request;
            if (hold_request > longest_hold)
               longest_hold = hold_request;
            hold_request = 0;
         end else if (took) begin
            gap_left = recv_stall_on ? $urandom_range(0, 4) : 0;
         end
         if (gap_left > 0) begin
            rsp_bus.ready <= 1'b0;
            gap_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Line driver. Every task is entered and left on a falling edge.
   // ------------------------------------------------------------------

   // Offer one line sample after a random gap and hold it until accepted.
   // Valid is left high on return; the next sample or a drain decides it.
   task automatic send_sample(input logic level);
      int gap;
      gap = send_idle_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.pin_level <= level;
      do @(posedge clock); while (!req_bus.ready);
      sample_count++;
      @(negedge clock);
   endtask

   // Stop offering samples and wait until every predicted byte has arrived
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (pending_bytes.size() != 0) @(negedge clock);
      repeat (DRAIN_SLACK) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input int value);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= CSR_DATA_WIDTH'(value);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_LIMIT_SHORT:     cfg_short     = LIMIT_WIDTH'(value);
         CSR_LIMIT_LONG:      cfg_long      = LIMIT_WIDTH'(value);
         CSR_FIXED_FRAME_LEN: cfg_fixed_len = BYTE_WIDTH'(value);
         default: ;
      endcase
      writes_done++;
      @(negedge clock);
   endtask

   // One bit cell: low samples, then high samples
   task automatic send_bit_timed(input int lows, input int highs);
      repeat (lows) send_sample(1'b0);
      repeat (highs) send_sample(1'b1);
      prev_capped = (highs >= 2 * int'(cfg_long));
   endtask

   // Random timing for a bit value. After a capped bit the high run may
   // follow at once; otherwise a low is needed to close the previous bit.
   task automatic send_bit(input logic bit_val);
      int lows;
      int highs;
      int zero_max;
      zero_max = (cfg_long > 255) ? 16 : int'(cfg_long);
      lows = $urandom_range(prev_capped ? 0 : 1, 3);
      if (bit_val)
         highs = $urandom_range(int'(cfg_long) + 1, 2 * int'(cfg_long));
      else
         highs = $urandom_range(1, zero_max);
      send_bit_timed(lows, highs);
   endtask

   function automatic int pick_sync_len();
      return $urandom_range(SYNC_MIN_SCALE * int'(cfg_short) + 1,
                            SYNC_MAX_SCALE * int'(cfg_long));
   endfunction

   // Idle high, falling edge, sync high of the given length, then the first
   // bit_limit bits of tx_bytes. Close with a low unless the last bit hit the
   // cap, and go back to idle high.
   task automatic send_frame(input int sync_len, input int bit_limit);
      repeat ($urandom_range(1, 3)) send_sample(1'b1);
      repeat ($urandom_range(1, 3)) send_sample(1'b0);
      repeat (sync_len) send_sample(1'b1);
      prev_capped = 1'b0;
      for (int k = 0; k < bit_limit; k++)
         send_bit(tx_bytes[k / 8][7 - (k % 8)]);
      if (!prev_capped)
         send_sample(1'b0);
      repeat ($urandom_range(1, 2)) send_sample(1'b1);
   endtask

   // Bring the decoder back to idle after a broken frame: run a sync high
   // into its timeout, or finish the frame with bits (zeros while the length
   // byte is still open, so the frame stays short).
   task automatic settle_line();
      int guard;
      guard = 0;
      while (line_phase != PH_IDLE && guard < 6000) begin
         if (line_phase == PH_SYNC_LOW || line_phase == PH_SYNC_HIGH)
            send_sample(1'b1);
         else
            send_bit(bytes_done == 8'd0 ? 1'b0 : 1'($urandom_range(0, 1)));
         guard++;
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset limits: length byte, all-ones and all-zeros data
   task automatic test_default_frame();
      tx_bytes = '{8'd3, 8'hFF, 8'h00};
      send_frame(pick_sync_len(), 24);
      drain_results();
   endtask

   // Exact boundaries of sync and bit timing, and bits closed by the cap
   task automatic test_bit_thresholds();
      write_reg(CSR_LIMIT_SHORT, 1);
      write_reg(CSR_LIMIT_LONG, 5);
      repeat (2) send_sample(1'b1);
      repeat (2) send_sample(1'b0);
      repeat (7) send_sample(1'b1);        // one above six times limit_short
      prev_capped = 1'b0;
      // Length byte 2: zeros at exactly limit_long, a one just above it
      repeat (6) send_bit_timed(1, 5);
      send_bit_timed(1, 6);
      send_bit_timed(1, 1);
      // Data 0xFF: capped bits back to back, then ordinary ones, then capped ones
      send_bit_timed(1, 10);
      send_bit_timed(0, 10);
      send_bit_timed(0, 10);
      send_bit_timed(1, 6);
      send_bit_timed(1, 9);
      send_bit_timed(2, 7);
      send_bit_timed(1, 10);
      send_bit_timed(0, 10);               // frame closes on this high sample
      repeat (3) send_sample(1'b1);
      drain_results();
   endtask

   // Sync high at the short limit, past the timeout, and at the timeout
   task automatic test_sync_rejects();
      write_reg(CSR_LIMIT_SHORT, 1);
      write_reg(CSR_LIMIT_LONG, 5);
      tx_bytes = '{8'd1};
      send_frame(6, 0);                    // abandoned; the closing low must not arm
      repeat (3) send_sample(1'b0);
      repeat (8) send_sample(1'b1);
      send_frame(50, 8);                   // longest accepted sync high
      send_frame(51, 0);                   // timed out; the closing low arms again
      repeat (3) send_sample(1'b1);
      send_sample(1'b0);
      settle_line();
      drain_results();
   endtask

   // Frame length from the first byte or from the register, below two as well
   task automatic test_length_cases();
      write_reg(CSR_LIMIT_SHORT, 1);
      write_reg(CSR_LIMIT_LONG, 3);
      tx_bytes = '{8'd1};
      send_frame(pick_sync_len(), 8);
      write_reg(CSR_FIXED_FRAME_LEN, 1);
      tx_bytes = '{8'd0};
      send_frame(pick_sync_len(), 8);
      write_reg(CSR_FIXED_FRAME_LEN, 0);
      tx_bytes = '{8'd0};
      send_frame(pick_sync_len(), 8);
      write_reg(CSR_FIXED_FRAME_LEN, 3);
      tx_bytes = '{8'd0, 8'hFF, 8'h00};
      send_frame(pick_sync_len(), 24);
      tx_bytes = '{8'd3, 8'h5A, 8'hA5};
      send_frame(pick_sync_len(), 24);
      drain_results();
   endtask

   // Register extremes, and the longest frame the length field allows
   task automatic test_limit_extremes();
      write_reg(CSR_LIMIT_SHORT, 65535);
      write_reg(CSR_LIMIT_LONG, 65535);
      tx_bytes = '{8'd1};
      send_frame(40, 0);                   // far too short a sync
      write_reg(CSR_LIMIT_SHORT, 0);
      write_reg(CSR_LIMIT_LONG, 0);
      send_frame(3, 0);                    // timeout on the first high
      settle_line();
      write_reg(CSR_LIMIT_LONG, 65535);
      write_reg(CSR_FIXED_FRAME_LEN, 1);
      tx_bytes = '{8'd0};
      send_frame(5, 8);
      write_reg(CSR_LIMIT_LONG, 1);
      write_reg(CSR_FIXED_FRAME_LEN, 255);
      tx_bytes = '{8'd0, 8'hFF, 8'h00};
      while (tx_bytes.size() < 255)
         tx_bytes.push_back(8'($urandom));
      send_frame(pick_sync_len(), 255 * 8);
      drain_results();
   endtask

   // Hold the receiver off while the sender keeps going, then pause the
   // sender until everything has come out
   task automatic test_backpressure();
      write_reg(CSR_LIMIT_SHORT, 0);
      write_reg(CSR_LIMIT_LONG, 1);
      write_reg(CSR_FIXED_FRAME_LEN, 16);
      send_idle_on = 1'b0;
      hold_request = 300;
      tx_bytes = '{8'd8};
      repeat (7) tx_bytes.push_back(8'($urandom));
      send_frame(pick_sync_len(), 64);
      drain_results();
      send_idle_on = 1'b1;
   endtask

   // Mostly well-formed frames with random content and limits; a third are
   // broken: short sync, timed-out sync, truncated frame or line noise
   task automatic test_random_traffic();
      int frames;
      int first_sample;
      int first_byte;
      int size;
      int kind;
      frames       = 0;
      first_sample = sample_count;
      first_byte   = byte_total;
      while (sample_count - first_sample < RANDOM_SAMPLES ||
             byte_total - first_byte < RANDOM_BYTES) begin
         if (frames % 5 == 0) begin
            write_reg(CSR_LIMIT_LONG, $urandom_range(1, 4));
            write_reg(CSR_LIMIT_SHORT, $urandom_range(0, int'(cfg_long)));
            write_reg(CSR_FIXED_FRAME_LEN, $urandom_range(0, 6));
            if ($urandom_range(0, 3) == 0)
               hold_request = $urandom_range(30, 120);
         end
         send_idle_on  = ($urandom_range(0, 3) != 0);
         recv_stall_on = ($urandom_range(0, 3) != 0);

         tx_bytes.delete();
         tx_bytes.push_back(8'($urandom_range(0, 5)));
         size = (tx_bytes[0] != 8'd0) ? int'(tx_bytes[0]) : int'(cfg_fixed_len);
         if (size == 0)
            size = 1;
         for (int i = 1; i < size; i++)
            tx_bytes.push_back(8'($urandom));

         kind = $urandom_range(0, 11);
         case (kind)
            0: send_frame($urandom_range(1, SYNC_MIN_SCALE * int'(cfg_short)), 0);
            1: send_frame(SYNC_MAX_SCALE * int'(cfg_long) + $urandom_range(1, 3), 0);
            2: send_frame(pick_sync_len(), $urandom_range(1, 8 * size - 1));
            3: repeat ($urandom_range(5, 40)) send_sample(1'($urandom_range(0, 1)));
            default: send_frame(pick_sync_len(), 8 * size);
         endcase
         settle_line();
         frames++;
      end
      send_idle_on  = 1'b1;
      recv_stall_on = 1'b1;
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      reset             = 1'b1;
      csr_write_enable  = 1'b0;
      csr_index         = CSR_LIMIT_SHORT;
      csr_write_data    = '0;
      req_bus.valid     = 1'b0;
      req_bus.pin_level = 1'b1;

      cfg_short     = LIMIT_SHORT_RESET;
      cfg_long      = LIMIT_LONG_RESET;
      cfg_fixed_len = FIXED_FRAME_LEN_RESET;
      line_phase    = PH_IDLE;
      last_level    = 1'b1;
      high_ticks    = '0;
      byte_shift    = '0;
      next_bit_pos  = 3'd7;
      bytes_done    = '0;
      frame_total   = '0;

      failures      = 0;
      cycle_count   = 0;
      sample_count  = 0;
      byte_total    = 0;
      frames_seen   = 0;
      writes_done   = 0;
      hold_request  = 0;
      longest_hold  = 0;
      send_idle_on  = 1'b1;
      recv_stall_on = 1'b1;
      prev_capped   = 1'b0;

      repeat (2) @(negedge clock);
      reset <= 1'b0;

      test_default_frame();
      test_bit_thresholds();
      test_sync_rejects();
      test_length_cases();
      test_limit_extremes();
      test_backpressure();
      test_random_traffic();

      drain_results();
      repeat (8) @(negedge clock);

      $display("Covered %0d line samples, %0d decoded bytes, %0d completed frames.",
               sample_count, byte_total, frames_seen);
      $display("Register writes: %0d; longest receiver hold-off: %0d cycles.",
               writes_done, longest_hold);
      if (failures == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/pwbr_pkg.sv
rtl/pwbr_if.sv
rtl/pwbr_csr.sv
rtl/pwbr_decode.sv
rtl/pulse_width_bus_receiver.sv
tb/tb_pulse_width_bus_receiver.sv
